// ===== hw/rtl/ihx_pkg.sv =====
package ihx_pkg;

   localparam int MEM_ADDR_BITS_DEFAULT = 16;

   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE_UP = 8'h3A;
   localparam logic [7:0] HEX_ALPHA_GAP = 8'd7;

   localparam logic [2:0] BYTE_DIGITS = 3'd2;
   localparam logic [2:0] WORD_DIGITS = 3'd4;

   localparam logic [7:0] RECORD_DATA    = 8'h00;
   localparam logic [7:0] RECORD_SEGMENT = 8'h02;

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   localparam int RSP_DEPTH    = 4;
   localparam int RSP_PTR_BITS = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS = $clog2(RSP_DEPTH + 1);

   typedef enum logic [3:0] {
      PH_LINE_START = 4'd0,
      PH_COUNT      = 4'd1,
      PH_ADDR       = 4'd2,
      PH_TYPE       = 4'd3,
      PH_DATA       = 4'd4,
      PH_SEG        = 4'd5,
      PH_SKIP       = 4'd6,
      PH_DONE       = 4'd7
   } phase_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] write_address;
      logic [7:0]  write_byte;
      logic [15:0] entry_address;
      logic        run_end;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } emit_type;

endpackage

// ===== hw/rtl/ihx_parser.sv =====
module ihx_parser
   import ihx_pkg::*;
#(
   parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     fire,
   input  req_type  req,
   output emit_type emit
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  digit_count_ff, digit_count_in;
   logic [15:0] field_value_ff, field_value_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [16:0] record_address_ff, record_address_in;
   logic [19:0] segment_offset_ff, segment_offset_in;
   logic [15:0] entry_point_ff, entry_point_in;

   logic        alpha_range;
   logic [9:0]  digit_value;
   logic        digit_ok;
   logic [15:0] field_tk;
   logic [2:0]  digit_tk;
   logic [20:0] addr_sum;
   logic        addr_ok;
   logic        is_newline;
   logic [7:0]  bytes_dec;
   phase_type   phase_body;

   logic        write_emit;
   logic        stop_emit;
   logic        last_emit;

   // hex digit decode, file convention
   assign alpha_range = req.char_in > CHAR_NINE_UP;
   assign digit_value = {2'b00, req.char_in} - {2'b00, CHAR_ZERO}
                      - (alpha_range ? {2'b00, HEX_ALPHA_GAP} : 10'd0);
   assign digit_ok    = (digit_value[9:4] == 6'd0);
   assign field_tk    = digit_ok ? {field_value_ff[11:0], digit_value[3:0]} : field_value_ff;
   assign digit_tk    = digit_count_ff + 3'd1;

   assign addr_sum   = {1'b0, segment_offset_ff} + {4'b0000, record_address_ff};
   assign addr_ok    = ((addr_sum >> MEM_ADDR_BITS) == 21'd0);
   assign is_newline = (req.char_in == CHAR_NEWLINE);
   assign bytes_dec  = bytes_left_ff - 8'd1;

   // next state
   always_comb begin
      phase_body        = phase_ff;
      digit_count_in    = digit_count_ff;
      field_value_in    = field_value_ff;
      bytes_left_in     = bytes_left_ff;
      record_address_in = record_address_ff;
      segment_offset_in = segment_offset_ff;
      entry_point_in    = entry_point_ff;
      if (is_newline) begin
         phase_body = PH_LINE_START;
      end else begin
         case (phase_ff)
            PH_LINE_START: begin
               if (req.char_in == CHAR_COLON) begin
                  phase_body     = PH_COUNT;
                  digit_count_in = 3'd0;
                  field_value_in = 16'd0;
               end else begin
                  phase_body = PH_SKIP;
               end
            end
            PH_COUNT: begin
               digit_count_in = digit_tk;
               field_value_in = field_tk;
               if (digit_tk == BYTE_DIGITS) begin
                  bytes_left_in  = field_tk[7:0];
                  phase_body     = PH_ADDR;
                  digit_count_in = 3'd0;
                  field_value_in = 16'd0;
               end
            end
            PH_ADDR: begin
               digit_count_in = digit_tk;
               field_value_in = field_tk;
               if (digit_tk == WORD_DIGITS) begin
                  record_address_in = {1'b0, field_tk};
                  phase_body        = PH_TYPE;
                  digit_count_in    = 3'd0;
                  field_value_in    = 16'd0;
               end
            end
            PH_TYPE: begin
               digit_count_in = digit_tk;
               field_value_in = field_tk;
               if (digit_tk == BYTE_DIGITS) begin
                  entry_point_in = record_address_ff[15:0];
                  if (field_tk[7:0] == RECORD_DATA) begin
                     if (bytes_left_ff != 8'd0) begin
                        phase_body     = PH_DATA;
                        digit_count_in = 3'd0;
                        field_value_in = 16'd0;
                     end else begin
                        phase_body = PH_SKIP;
                     end
                  end else if (field_tk[7:0] == RECORD_SEGMENT) begin
                     phase_body     = PH_SEG;
                     digit_count_in = 3'd0;
                     field_value_in = 16'd0;
                  end else begin
                     phase_body = PH_DONE;
                  end
               end
            end
            PH_DATA: begin
               digit_count_in = digit_tk;
               field_value_in = field_tk;
               if (digit_tk == BYTE_DIGITS) begin
                  if (addr_ok) begin
                     record_address_in = record_address_ff + 17'd1;
                  end
                  bytes_left_in = bytes_dec;
                  if (bytes_dec == 8'd0) begin
                     phase_body = PH_SKIP;
                  end else begin
                     phase_body     = PH_DATA;
                     digit_count_in = 3'd0;
                     field_value_in = 16'd0;
                  end
               end
            end
            PH_SEG: begin
               digit_count_in = digit_tk;
               field_value_in = field_tk;
               if (digit_tk == WORD_DIGITS) begin
                  segment_offset_in = {field_tk, 4'h0};
                  phase_body        = PH_SKIP;
               end
            end
            default: begin
               phase_body = PH_SKIP;
            end
         endcase
      end
      phase_in = (req.last_char) ? PH_DONE : phase_body;
   end

   // results
   always_comb begin
      write_emit = !is_newline && (phase_ff == PH_DATA) && (digit_tk == BYTE_DIGITS)
                 && addr_ok;
      stop_emit  = !is_newline && (phase_ff == PH_TYPE) && (digit_tk == BYTE_DIGITS)
                 && (field_tk[7:0] != RECORD_DATA) && (field_tk[7:0] != RECORD_SEGMENT);
      last_emit  = req.last_char && (phase_body != PH_DONE);

      emit.first.kind          = stop_emit ? KIND_FINISH : KIND_WRITE;
      emit.first.write_address = write_emit ? addr_sum[15:0] : 16'd0;
      emit.first.write_byte    = write_emit ? field_tk[7:0] : 8'd0;
      emit.first.entry_address = entry_point_in;
      emit.first.run_end       = !last_emit;

      emit.second.kind          = KIND_FINISH;
      emit.second.write_address = 16'd0;
      emit.second.write_byte    = 8'd0;
      emit.second.entry_address = entry_point_in;
      emit.second.run_end       = 1'b1;

      if (phase_ff == PH_DONE) begin
         emit.count = 2'd0;
      end else if (write_emit || stop_emit) begin
         emit.count = last_emit ? 2'd2 : 2'd1;
      end else if (last_emit) begin
         emit.count  = 2'd1;
         emit.first  = emit.second;
      end else begin
         emit.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_LINE_START;
         digit_count_ff    <= 3'd0;
         field_value_ff    <= 16'd0;
         bytes_left_ff     <= 8'd0;
         record_address_ff <= 17'd0;
         segment_offset_ff <= 20'd0;
         entry_point_ff    <= 16'd0;
      end else if (fire && (phase_ff != PH_DONE)) begin
         phase_ff          <= phase_in;
         digit_count_ff    <= digit_count_in;
         field_value_ff    <= field_value_in;
         bytes_left_ff     <= bytes_left_in;
         record_address_ff <= record_address_in;
         segment_offset_ff <= segment_offset_in;
         entry_point_ff    <= entry_point_in;
      end
   end

endmodule

// ===== hw/rtl/ihx_rsp_fifo.sv =====
module ihx_rsp_fifo
   import ihx_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  emit_type emit,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   rsp_type                 entry_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_BITS-1:0] count_ff, count_in;
   logic [1:0]              push_cnt;
   logic                    pop;
   logic [RSP_PTR_BITS-1:0] wr_ptr_next;

   assign push_cnt    = push ? emit.count : 2'd0;
   assign pop         = rsp_valid && !rsp_stall;
   assign wr_ptr_next = wr_ptr_ff + RSP_PTR_BITS'(1);

   // two free slots needed for a worst case request
   assign room      = (count_ff <= RSP_CNT_BITS'(RSP_DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_BITS'(push_cnt);
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_BITS'(push_cnt) - RSP_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         entry_ff[wr_ptr_ff] <= emit.first;
      end
      if (push_cnt == 2'd2) begin
         entry_ff[wr_ptr_next] <= emit.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/intel_hex_record_loader.sv =====
// Intel HEX record loader.
// req channel: one file character per request (char_in, last_char), taken at
// a clock edge with req_valid high and req_stall low.
// rsp channel: memory byte writes (kind 0) and one finish result (kind 1),
// taken at an edge with rsp_valid high and rsp_stall low; run_end marks the
// last result of a request, which makes zero, one or two results.
// A request is registered on acceptance, parsed from that register once the
// four-entry output queue has room, and its results land in that queue.
// Throughput is one character per cycle while the output queue has room; a
// request that makes two results drains through the single-result port.
// req_stall rises only while a request is held in the input register and
// the output queue has fewer than two free entries, so a stalled receiver
// backs up into the request side once the queue fills.
// Reset clears the parser to line start with zero offsets and entry point
// and empties the queue. After a finish result every further character is
// taken and dropped until the next reset.
module intel_hex_record_loader
   import ihx_pkg::*;
#(
   parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic     in_vld_ff, in_vld_in;
   req_type  in_data_ff;
   logic     room;
   logic     fire;
   emit_type emit;

   assign fire      = in_vld_ff && room;
   assign req_stall = in_vld_ff && !room;
   assign in_vld_in = (req_valid && !req_stall) ? 1'b1 : (fire ? 1'b0 : in_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   ihx_parser #(
      .MEM_ADDR_BITS(MEM_ADDR_BITS)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .fire (fire),
      .req  (in_data_ff),
      .emit (emit)
   );

   ihx_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (fire),
      .emit     (emit),
      .room     (room),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule
